>>> rtl/cpa_pkg.sv
// ----------------------------------------------------------------------------
// cpa_pkg - shared types and constants for the CAN proximity alarm
// Frame identifiers, zone offset, beep and keepalive timing, register
// addresses and the lane/merge status structures.
// ----------------------------------------------------------------------------
`default_nettype none

package cpa_pkg;

    // Number of distance lanes (one per frame data byte)
    localparam int NUM_LANES = 4;

    // Recognised identifiers
    localparam logic [28:0] STD_ID_A = 29'h310;
    localparam logic [28:0] STD_ID_B = 29'h320;
    localparam logic [28:0] EXT_ID_A = 29'h18FF5B80;
    localparam logic [28:0] EXT_ID_B = 29'h18FF5B81;

    // Standard frames carry distance + 80 in byte 3
    localparam logic [12:0] STD_OFFSET = 13'd80;

    // Beep reload values (period minus one, in ms ticks)
    localparam logic [8:0] FAST_RELOAD = 9'd99;
    localparam logic [8:0] SLOW_RELOAD = 9'd499;

    // Keepalive interval in ms ticks
    localparam logic [6:0] KEEPALIVE_MS = 7'd100;

    // Input kinds
    localparam logic ACT_FRAME = 1'b0;
    localparam logic ACT_TICK  = 1'b1;

    // Sensor modes that need keepalive
    localparam logic [1:0] MODE_KA_A = 2'd1;
    localparam logic [1:0] MODE_KA_B = 2'd2;

    // Register byte addresses
    localparam logic [3:0] ADDR_SENSOR_MODE = 4'h0;
    localparam logic [3:0] ADDR_DANGER_ZONE = 4'h4;
    localparam logic [3:0] ADDR_WARN_ZONE   = 4'h8;
    localparam logic [3:0] ADDR_AUDIO_EN    = 4'hC;

    // Reset values of the registers
    localparam logic [1:0]  RST_SENSOR_MODE = 2'd0;
    localparam logic [11:0] RST_DANGER_ZONE = 12'd5;
    localparam logic [11:0] RST_WARN_ZONE   = 12'd15;
    localparam logic        RST_AUDIO_EN    = 1'b1;

    // What one lane found
    typedef struct packed {
        logic below_danger;
        logic below_warning;
    } lane_hit_t;

    // Merged zone verdict for one frame
    typedef struct packed {
        logic danger;
        logic warning;
    } zone_hit_t;

endpackage

`default_nettype wire

>>> rtl/cpa_lane.sv
// ----------------------------------------------------------------------------
// cpa_lane - one distance lane
// Compares one data byte against the danger and warning zone limits, each
// optionally raised by the standard-frame offset.
// ----------------------------------------------------------------------------
`default_nettype none

module cpa_lane
    import cpa_pkg::*;
(
    input  wire logic [7:0]  dist_byte,
    input  wire logic        add_offset,
    input  wire logic [11:0] danger_lim,
    input  wire logic [11:0] warn_lim,
    output lane_hit_t        hit
);

    logic [12:0] lim_offset;

    assign lim_offset = add_offset ? STD_OFFSET : 13'd0;

    // byte - 80 < limit  is  byte < limit + 80; kept unsigned
    always_comb begin
        hit.below_danger  = ({5'd0, dist_byte} < ({1'b0, danger_lim} + lim_offset));
        hit.below_warning = ({5'd0, dist_byte} < ({1'b0, warn_lim} + lim_offset));
    end

endmodule

`default_nettype wire

>>> rtl/cpa_merge.sv
// ----------------------------------------------------------------------------
// cpa_merge - identifier decode and lane merge
// Decodes the frame type from its identifier and merges the lanes: any lane
// (for std frames the top one) below a zone puts the nearest object in it.
// ----------------------------------------------------------------------------
`default_nettype none

module cpa_merge
    import cpa_pkg::*;
(
    input  wire logic                  is_extended,
    input  wire logic [28:0]           frame_id,
    input  wire lane_hit_t [NUM_LANES-1:0] lane_hit,
    output logic                       std_frame,
    output zone_hit_t                  zone
);

    logic ext_frame;
    logic any_danger;
    logic any_warning;

    // Identifier decode
    assign std_frame = !is_extended && (frame_id inside {STD_ID_A, STD_ID_B});
    assign ext_frame =  is_extended && (frame_id inside {EXT_ID_A, EXT_ID_B});

    // Minimum below a limit is any lane below it
    always_comb begin
        any_danger  = 1'b0;
        any_warning = 1'b0;
        for (int i = 0; i < NUM_LANES; i++) begin
            any_danger  = any_danger  | lane_hit[i].below_danger;
            any_warning = any_warning | lane_hit[i].below_warning;
        end
    end

    // Unknown frames read as no object, above every zone
    always_comb begin
        zone.danger  = 1'b0;
        zone.warning = 1'b0;
        if (std_frame) begin
            zone.danger  = lane_hit[NUM_LANES-1].below_danger;
            zone.warning = lane_hit[NUM_LANES-1].below_warning;
        end else if (ext_frame) begin
            zone.danger  = any_danger;
            zone.warning = any_warning;
        end
    end

endmodule

`default_nettype wire

>>> rtl/can_proximity_alarm.sv
// ----------------------------------------------------------------------------
// can_proximity_alarm - CAN proximity alarm with buzzer and keepalive
// Frames set or clear the alarm from the nearest distance; 1 ms ticks
// drive the buzzer and the keepalive request.
//
//   Channel  Ports        Direction  Content
//   s_       tdata/tuser  in         frame or tick
//   m_       tdata        out        alarm status, one per input transfer
//   APB      p*           in/out     four configuration registers
//
// Each input transfer yields its result in the output register in the next
// cycle; one transfer per cycle is sustained while m_tready is high. Four byte
// lanes compare in parallel and a merge stage combines them in the same cycle.
// The input is taken whenever the output register is empty or being drained.
// Reset (aresetn low, synchronous) clears alarm, buzzer and timers and loads
// the register defaults; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module can_proximity_alarm
    import cpa_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [28:0] frame_id, [36:29] byte0, [44:37] byte1, [52:45] byte2,
    // [60:53] byte3, [63:61] zero
    input  wire logic [63:0] s_tdata,
    // [0] action, [1] is_extended
    input  wire logic [1:0]  s_tuser,
    // Result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [0] buzzer_pin, [1] alarm_on, [2] fast_beep, [3] send_keepalive,
    // [4] danger_event, [7:5] zero
    output logic [7:0]       m_tdata,
    // Configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    // Configuration registers
    logic [1:0]  sensor_mode_reg;
    logic [11:0] danger_lim_reg;
    logic [11:0] warn_lim_reg;
    logic        audio_en_reg;

    // Alarm state
    logic        alarm_reg,     alarm_next;
    logic        fast_reg,      fast_next;
    logic [8:0]  countdown_reg, countdown_next;
    logic        phase_reg,     phase_next;
    logic [6:0]  elapsed_reg,   elapsed_next;
    logic [6:0]  elapsed_inc;

    // Output register
    logic        out_valid_reg;
    logic [4:0]  out_data_reg, out_data_next;

    // Input unpacking
    logic        action;
    logic        is_extended;
    logic [28:0] frame_id;
    logic [7:0]  data_byte [NUM_LANES];
    logic        std_frame;
    logic        in_xfer;
    logic        cfg_write;
    logic        keepalive;
    logic        danger;

    lane_hit_t [NUM_LANES-1:0] lane_hit;
    zone_hit_t                 zone;

    assign action      = s_tuser[0];
    assign is_extended = s_tuser[1];
    assign frame_id    = s_tdata[28:0];
    assign data_byte[0] = s_tdata[36:29];
    assign data_byte[1] = s_tdata[44:37];
    assign data_byte[2] = s_tdata[52:45];
    assign data_byte[3] = s_tdata[60:53];

    // Handshakes
    assign s_tready = !out_valid_reg || m_tready;
    assign in_xfer  = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'd0, out_data_reg};

    // Distance lanes; the top lane also takes the standard-frame offset
    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        cpa_lane u_lane (
            .dist_byte  (data_byte[g]),
            .add_offset ((g == NUM_LANES - 1) ? std_frame : 1'b0),
            .danger_lim (danger_lim_reg),
            .warn_lim   (warn_lim_reg),
            .hit        (lane_hit[g])
        );
    end

    cpa_merge u_merge (
        .is_extended (is_extended),
        .frame_id    (frame_id),
        .lane_hit    (lane_hit),
        .std_frame   (std_frame),
        .zone        (zone)
    );

    // Next state for one transfer
    assign elapsed_inc = (elapsed_reg < KEEPALIVE_MS) ? (elapsed_reg + 7'd1) : elapsed_reg;

    always_comb begin
        alarm_next     = alarm_reg;
        fast_next      = fast_reg;
        countdown_next = countdown_reg;
        phase_next     = phase_reg;
        elapsed_next   = elapsed_reg;
        keepalive      = 1'b0;
        danger         = 1'b0;
        if (action == ACT_FRAME) begin
            if (zone.danger) begin
                alarm_next = 1'b1;
                fast_next  = 1'b1;
                danger     = 1'b1;
            end else if (zone.warning) begin
                alarm_next = 1'b1;
                fast_next  = 1'b0;
            end else begin
                alarm_next = 1'b0;
            end
        end else begin
            // buzzer toggling
            if (alarm_reg && audio_en_reg) begin
                if (countdown_reg == 9'd0) begin
                    phase_next     = !phase_reg;
                    countdown_next = fast_reg ? FAST_RELOAD : SLOW_RELOAD;
                end else begin
                    countdown_next = countdown_reg - 9'd1;
                end
            end else begin
                phase_next     = 1'b0;
                countdown_next = 9'd0;
            end
            // keepalive timer, saturating
            elapsed_next = elapsed_inc;
            if ((sensor_mode_reg inside {MODE_KA_A, MODE_KA_B}) &&
                elapsed_inc >= KEEPALIVE_MS) begin
                keepalive    = 1'b1;
                elapsed_next = 7'd0;
            end
        end
        out_data_next = {danger, keepalive, fast_next, alarm_next, phase_next};
    end

    // State and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alarm_reg     <= 1'b0;
            fast_reg      <= 1'b0;
            countdown_reg <= 9'd0;
            phase_reg     <= 1'b0;
            elapsed_reg   <= 7'd0;
            out_valid_reg <= 1'b0;
        end else begin
            if (in_xfer) begin
                alarm_reg     <= alarm_next;
                fast_reg      <= fast_next;
                countdown_reg <= countdown_next;
                phase_reg     <= phase_next;
                elapsed_reg   <= elapsed_next;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            out_data_reg <= out_data_next;
        end
    end

    // Configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sensor_mode_reg <= RST_SENSOR_MODE;
            danger_lim_reg  <= RST_DANGER_ZONE;
            warn_lim_reg    <= RST_WARN_ZONE;
            audio_en_reg    <= RST_AUDIO_EN;
        end else if (cfg_write) begin
            case (paddr)
                ADDR_SENSOR_MODE: sensor_mode_reg <= pwdata[1:0];
                ADDR_DANGER_ZONE: danger_lim_reg  <= pwdata[11:0];
                ADDR_WARN_ZONE:   warn_lim_reg    <= pwdata[11:0];
                ADDR_AUDIO_EN:    audio_en_reg    <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Read-back
    always_comb begin
        case (paddr)
            ADDR_SENSOR_MODE: prdata = {30'd0, sensor_mode_reg};
            ADDR_DANGER_ZONE: prdata = {20'd0, danger_lim_reg};
            ADDR_WARN_ZONE:   prdata = {20'd0, warn_lim_reg};
            ADDR_AUDIO_EN:    prdata = {31'd0, audio_en_reg};
            default:          prdata = 32'd0;
        endcase
    end

`ifndef SYNTHESIS
    // A danger result always carries an active fast alarm
    a_danger_fast: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[4]) |-> (m_tdata[1] && m_tdata[2]))
        else $error("danger_event without fast alarm");

    // Keepalive timer saturates at its interval
    a_elapsed_max: assert property (@(posedge aclk) disable iff (!aresetn)
        elapsed_reg <= KEEPALIVE_MS)
        else $error("keepalive timer overrun");

    // Beep countdown stays within the slow period
    a_countdown_max: assert property (@(posedge aclk) disable iff (!aresetn)
        countdown_reg <= SLOW_RELOAD)
        else $error("beep countdown overrun");

    // An accepted transfer is always followed by a result
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer |=> m_tvalid)
        else $error("result missing after input transfer");
`endif

endmodule

`default_nettype wire

>>> verif/can_proximity_alarm_tb.sv
// ----------------------------------------------------------------------------
// can_proximity_alarm_tb - self-checking bench for the CAN proximity alarm
// Drives frames and 1 ms ticks into the input stream and works out each alarm
// status word in a cycle-free predictor of its own. Every result transfer is
// compared field by field with the oldest predicted word. The zones, sensor
// mode and audio enable are rewritten over the APB port between phases, once
// the block has drained. Both stream sides idle at random, and one phase
// holds the result side off long enough to back the input up.
// ----------------------------------------------------------------------------
`default_nettype none

module can_proximity_alarm_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cpa_pkg::*;

    localparam int IDLE_LIMIT   = 2000;
    localparam int HOLD_CYCLES  = 80;
    localparam int CHUNK_ITEMS  = 12;

    // Sensor modes without keepalive
    localparam logic [1:0] MODE_PLAIN = 2'd0;
    localparam logic [1:0] MODE_SPARE = 2'd3;

    // Frames that carry no object report this distance
    localparam logic signed [14:0] NO_OBJECT_DM = 15'sd9990;
    // Keepalive frame identifier, not a distance frame
    localparam logic [28:0] KEEPALIVE_ID = 29'h18FF5A54;
    localparam logic [28:0] ID_ALL_ONES  = 29'h1FFFFFFF;

    // Result word, lowest bit last
    typedef struct packed {
        logic danger_event;
        logic send_keepalive;
        logic fast_beep;
        logic alarm_on;
        logic buzzer_pin;
    } alarm_status_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    // [28:0] frame_id, [36:29] byte0, [44:37] byte1, [52:45] byte2,
    // [60:53] byte3, [63:61] zero
    logic [63:0] s_tdata;
    // [0] action, [1] is_extended
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    // [0] buzzer_pin, [1] alarm_on, [2] fast_beep, [3] send_keepalive,
    // [4] danger_event, [7:5] zero
    logic [7:0]  m_tdata;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    can_proximity_alarm DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Predicted register contents
    logic [1:0]  cfg_mode   = RST_SENSOR_MODE;
    logic [11:0] cfg_danger = RST_DANGER_ZONE;
    logic [11:0] cfg_warn   = RST_WARN_ZONE;
    logic        cfg_audio  = RST_AUDIO_EN;

    // Predicted alarm state
    logic        alarm_q    = 1'b0;
    logic        fast_q     = 1'b0;
    logic [8:0]  countdown_q = '0;
    logic        buzzer_q   = 1'b0;
    logic [6:0]  ka_elapsed_q = '0;

    alarm_status_t status_q[$];
    int mismatches   = 0;
    int src_idle_pct = 28;
    int snk_idle_pct = 56;
    int hold_left    = 0;
    int stall_cycles = 0;

    // Clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Nearest object distance in decimetres carried by one frame
    function automatic logic signed [14:0] nearest_dm(input logic ext,
                                                      input logic [28:0] id,
                                                      input logic [7:0] b0, b1,
                                                      input logic [7:0] b2, b3);
        logic [7:0] lo;
        if (!ext) begin
            if (id == STD_ID_A || id == STD_ID_B)
                return $signed({7'b0, b3}) - 15'sd80;
            return NO_OBJECT_DM;
        end
        if (id != EXT_ID_A && id != EXT_ID_B)
            return NO_OBJECT_DM;
        lo = b0;
        if (b1 < lo) lo = b1;
        if (b2 < lo) lo = b2;
        if (b3 < lo) lo = b3;
        return $signed({7'b0, lo});
    endfunction

    // Advance the predicted state by one input transfer, return its status
    function alarm_status_t predict_status(input logic act, input logic ext,
                                           input logic [28:0] id,
                                           input logic [7:0] b0, b1, b2, b3);
        alarm_status_t st;
        logic signed [14:0] range_dm;
        st = '0;
        if (act == ACT_FRAME) begin
            range_dm = nearest_dm(ext, id, b0, b1, b2, b3);
            if (range_dm < $signed({3'b000, cfg_danger})) begin
                alarm_q = 1'b1;
                fast_q  = 1'b1;
                st.danger_event = 1'b1;
            end else if (range_dm < $signed({3'b000, cfg_warn})) begin
                alarm_q = 1'b1;
                fast_q  = 1'b0;
            end else begin
                alarm_q = 1'b0;
            end
        end else begin
            // buzzer: toggle when the countdown runs out
            if (alarm_q && cfg_audio) begin
                if (countdown_q == '0) begin
                    buzzer_q    = ~buzzer_q;
                    countdown_q = fast_q ? FAST_RELOAD : SLOW_RELOAD;
                end else begin
                    countdown_q = countdown_q - 9'd1;
                end
            end else begin
                buzzer_q    = 1'b0;
                countdown_q = '0;
            end
            // keepalive: elapsed count saturates at the interval
            if (ka_elapsed_q < KEEPALIVE_MS)
                ka_elapsed_q = ka_elapsed_q + 7'd1;
            if ((cfg_mode == MODE_KA_A || cfg_mode == MODE_KA_B) &&
                ka_elapsed_q >= KEEPALIVE_MS) begin
                st.send_keepalive = 1'b1;
                ka_elapsed_q = '0;
            end
        end
        st.buzzer_pin = buzzer_q;
        st.alarm_on   = alarm_q;
        st.fast_beep  = fast_q;
        return st;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("%0t mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
        mismatches++;
    endtask

    // Compare each result transfer with the oldest prediction
    always @(posedge aclk) begin : check_results
        alarm_status_t got;
        alarm_status_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = alarm_status_t'(m_tdata[4:0]);
            if (status_q.size() == 0) begin
                report_mismatch("result with nothing outstanding", m_tdata, 8'h00);
            end else begin
                want = status_q.pop_front();
                if (got.buzzer_pin != want.buzzer_pin)
                    report_mismatch("buzzer_pin", 8'(got.buzzer_pin),
                                    8'(want.buzzer_pin));
                if (got.alarm_on != want.alarm_on)
                    report_mismatch("alarm_on", 8'(got.alarm_on), 8'(want.alarm_on));
                if (got.fast_beep != want.fast_beep)
                    report_mismatch("fast_beep", 8'(got.fast_beep), 8'(want.fast_beep));
                if (got.send_keepalive != want.send_keepalive)
                    report_mismatch("send_keepalive", 8'(got.send_keepalive),
                                    8'(want.send_keepalive));
                if (got.danger_event != want.danger_event)
                    report_mismatch("danger_event", 8'(got.danger_event),
                                    8'(want.danger_event));
            end
        end
    end

    // Watchdog: too long without any transfer on either stream
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= IDLE_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // Result side: random stalls, or a long hold-off on request
    initial begin : result_sink
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Offer one item and wait for its transfer; valid is left high
    task automatic push_input(input logic act, input logic ext,
                              input logic [28:0] id,
                              input logic [7:0] b0, b1, b2, b3);
        @(negedge aclk);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= {ext, act};
        s_tdata  <= {3'b000, b3, b2, b1, b0, id};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        status_q.push_back(predict_status(act, ext, id, b0, b1, b2, b3));
    endtask

    task automatic send_frame(input logic ext, input logic [28:0] id,
                              input logic [7:0] b0, b1, b2, b3);
        push_input(ACT_FRAME, ext, id, b0, b1, b2, b3);
    endtask

    // Ticks carry junk in the frame fields
    task automatic send_ticks(input int n);
        repeat (n)
            push_input(ACT_TICK, 1'($urandom()), 29'($urandom()), 8'($urandom()),
                       8'($urandom()), 8'($urandom()), 8'($urandom()));
    endtask

    // Drop valid and wait until every predicted result has come back
    task automatic wait_for_results;
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (status_q.size() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    task automatic apb_write(input logic [3:0] addr, input logic [31:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= addr;
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Rewrite all four registers once idle; unused upper bits are junk
    task automatic configure(input logic [1:0] mode, input logic [11:0] danger,
                             input logic [11:0] warn, input logic audio);
        wait_for_results();
        apb_write(ADDR_SENSOR_MODE, {30'($urandom()), mode});
        cfg_mode = mode;
        apb_write(ADDR_DANGER_ZONE, {20'($urandom()), danger});
        cfg_danger = danger;
        apb_write(ADDR_WARN_ZONE, {20'($urandom()), warn});
        cfg_warn = warn;
        apb_write(ADDR_AUDIO_EN, {31'($urandom()), audio});
        cfg_audio = audio;
    endtask

    function automatic logic [11:0] pick_zone();
        case ($urandom_range(0, 5))
            0:       return 12'd0;
            1:       return 12'd4095;
            2:       return 12'($urandom_range(1, 30));
            3:       return 12'($urandom_range(30, 200));
            4:       return 12'($urandom_range(0, 4095));
            default: return 12'($urandom_range(5, 60));
        endcase
    endfunction

    // One frame: mostly recognised identifiers, the rest noise and near misses
    task automatic send_random_frame;
        int sel;
        logic [7:0] b [4];
        logic [28:0] id;
        logic ext;
        sel = $urandom_range(0, 99);
        foreach (b[i]) b[i] = 8'($urandom());
        if (sel < 35) begin
            ext = 1'b0;
            id  = $urandom_range(0, 1) ? STD_ID_A : STD_ID_B;
            if ($urandom_range(0, 1)) b[3] = 8'($urandom_range(60, 140));
        end else if (sel < 65) begin
            ext = 1'b1;
            id  = $urandom_range(0, 1) ? EXT_ID_A : EXT_ID_B;
            if ($urandom_range(0, 1)) b[$urandom_range(0, 3)] = 8'($urandom_range(0, 40));
        end else if (sel < 85) begin
            ext = 1'($urandom());
            id  = 29'($urandom());
        end else begin
            ext = 1'($urandom());
            case ($urandom_range(0, 4))
                0:       id = STD_ID_A;
                1:       id = STD_ID_B;
                2:       id = EXT_ID_A;
                3:       id = EXT_ID_B;
                default: id = KEEPALIVE_ID;
            endcase
            if ($urandom_range(0, 1)) id = id ^ (29'd1 << $urandom_range(0, 28));
        end
        send_frame(ext, id, b[0], b[1], b[2], b[3]);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Distance decoding and zone edges with the reset zones (5 and 15 dm)
    task automatic test_frame_decoding;
        send_frame(1'b0, STD_ID_A, 8'hFF, 8'hFF, 8'hFF, 8'd0);   // -80 dm, danger
        send_frame(1'b0, STD_ID_B, 8'h00, 8'h00, 8'h00, 8'd84);  // 4 dm, danger
        send_frame(1'b0, STD_ID_A, 8'h00, 8'h00, 8'h00, 8'd85);  // on danger limit
        send_frame(1'b0, STD_ID_B, 8'hA5, 8'h5A, 8'h00, 8'd94);  // 14 dm, warning
        send_frame(1'b0, STD_ID_A, 8'h00, 8'h00, 8'h00, 8'd95);  // on warning limit
        send_frame(1'b0, STD_ID_B, 8'h00, 8'h00, 8'h00, 8'd255); // 175 dm
        send_frame(1'b1, EXT_ID_A, 8'd200, 8'd3, 8'd100, 8'd50); // min 3, danger
        send_frame(1'b1, EXT_ID_B, 8'd20, 8'd14, 8'd30, 8'd255); // min 14, warning
        send_frame(1'b1, EXT_ID_A, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_frame(1'b1, EXT_ID_B, 8'd9, 8'd0, 8'd7, 8'd255);    // zero distance
        send_frame(1'b1, EXT_ID_A, 8'd100, 8'd100, 8'd100, 8'd4); // min in byte 3
        // identifiers with the wrong frame format mean no object
        send_frame(1'b1, STD_ID_A, 8'd0, 8'd0, 8'd0, 8'd0);
        send_frame(1'b0, EXT_ID_A, 8'd0, 8'd0, 8'd0, 8'd0);
        send_frame(1'b0, ID_ALL_ONES, 8'd0, 8'd0, 8'd0, 8'd0);
        send_frame(1'b1, ID_ALL_ONES, 8'd0, 8'd0, 8'd0, 8'd0);
        send_frame(1'b1, 29'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        send_frame(1'b1, KEEPALIVE_ID, 8'd0, 8'd0, 8'd0, 8'd0);
        // buzzer keeps its level when a frame clears the alarm
        send_frame(1'b0, STD_ID_A, 8'd0, 8'd0, 8'd0, 8'd80);
        send_ticks(2);
        send_frame(1'b0, STD_ID_B, 8'd0, 8'd0, 8'd0, 8'd200);
        send_ticks(1);
    endtask

    // Fast and slow periods, a period change mid-count, audio switched off
    task automatic test_beep_periods;
        configure(MODE_PLAIN, RST_DANGER_ZONE, RST_WARN_ZONE, 1'b1);
        send_frame(1'b0, STD_ID_A, 8'd0, 8'd0, 8'd0, 8'd80);    // danger
        send_ticks(150);
        send_frame(1'b0, STD_ID_B, 8'd0, 8'd0, 8'd0, 8'd90);    // warning
        send_ticks(560);
        configure(MODE_PLAIN, RST_DANGER_ZONE, RST_WARN_ZONE, 1'b0);
        send_ticks(3);
        configure(MODE_PLAIN, RST_DANGER_ZONE, RST_WARN_ZONE, 1'b1);
        send_ticks(2);
    endtask

    // Keepalive in every sensor mode, saturation carried into a switch
    task automatic test_keepalive;
        logic [1:0] modes [4];
        modes = '{MODE_PLAIN, MODE_KA_A, MODE_SPARE, MODE_KA_B};
        foreach (modes[i]) begin
            configure(modes[i], 12'd0, 12'd4095, 1'b1);
            send_ticks(30);
            send_random_frame();
            send_ticks(30);
        end
    endtask

    // Result side held off while the input keeps offering items
    task automatic test_back_pressure;
        int saved;
        saved = src_idle_pct;
        src_idle_pct = 0;
        hold_left = HOLD_CYCLES;
        repeat (12) begin
            send_random_frame();
            send_ticks(1);
        end
        wait_for_results();
        src_idle_pct = saved;
    endtask

    // Frames followed by tick bursts over many register settings
    task automatic test_random;
        int count;
        int n;
        logic [11:0] danger;
        logic [11:0] warn;
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0:       begin src_idle_pct = 28; snk_idle_pct = 56; end
                1:       begin src_idle_pct = 56; snk_idle_pct = 28; end
                default: begin src_idle_pct = 0;  snk_idle_pct = 0;  end
            endcase
            for (int chunk = 0; chunk < 2; chunk++) begin
                danger = pick_zone();
                warn   = pick_zone();
                if (phase == 0 && chunk == 0) begin
                    danger = 12'd0;
                    warn   = 12'd0;
                end else if (phase == 0 && chunk == 1) begin
                    danger = 12'd4095;
                    warn   = 12'd4095;
                end
                configure(2'($urandom()), danger, warn, $urandom_range(0, 3) != 0);
                count = 0;
                while (count < CHUNK_ITEMS) begin
                    send_random_frame();
                    n = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 130)
                                                    : $urandom_range(0, 25);
                    send_ticks(n);
                    count += n + 1;
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_frame_decoding();
        test_beep_periods();
        test_keepalive();
        test_back_pressure();
        test_random();

        wait_for_results();
        repeat (8) @(posedge aclk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire
